FILE: hdl/radar_point_frame_transform_macros.svh
// Assertion macros used by the top level of the radar point frame transform.
`ifndef RADAR_POINT_FRAME_TRANSFORM_MACROS_SVH
`define RADAR_POINT_FRAME_TRANSFORM_MACROS_SVH
// Checks an implication on every clock edge outside reset.
`define RPFT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent, on every clock edge outside reset.
`define RPFT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/rpft_pkg.sv
// Shared types, constants and fixed-point helpers of the radar point frame transform.
`timescale 1ns / 1ps
package rpft_pkg;
    localparam int CoordW = 32;
    localparam int AttrW  = 16;
    localparam int QW     = 16;
    localparam int VecW   = 36;
    localparam int RegW   = 64;
    localparam int IdxW   = 3;
    localparam int TdataInW  = 3 * CoordW + 3 * AttrW;
    localparam int TdataOutW = 3 * CoordW + 3 * AttrW;

    typedef enum logic [IdxW-1:0] {
        REG_RX_ROT   = 3'd0,
        REG_RX_EAST  = 3'd1,
        REG_RX_NORTH = 3'd2,
        REG_RX_UP    = 3'd3,
        REG_CUR_ROT  = 3'd4,
        REG_CUR_EAST = 3'd5,
        REG_CUR_NORTH = 3'd6,
        REG_CUR_UP   = 3'd7
    } reg_idx_t;

    // Quaternion components, widened by one bit so the negation of -2.0 (the most negative value) fits.
    typedef struct packed {
        logic signed [QW:0] x;
        logic signed [QW:0] y;
        logic signed [QW:0] z;
        logic signed [QW:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [AttrW-1:0] radar_velocity;
        logic signed [AttrW-1:0] ground_velocity;
        logic signed [AttrW-1:0] snr;
    } attr_t;

    function automatic quat_t unpack_quat(input logic [RegW-1:0] r, input logic conj);
        quat_t q;
        q.x = {r[15], r[15:0]};
        q.y = {r[31], r[31:16]};
        q.z = {r[47], r[47:32]};
        q.w = {r[63], r[63:48]};
        if (conj) begin
            q.x = -q.x;
            q.y = -q.y;
            q.z = -q.z;
        end
        return q;
    endfunction

    // Arithmetic shift right by k with round half up.
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] x,
                                                     input int k);
        logic signed [63:0] t;
        t = x + (64'sd1 <<< (k - 1));
        return t >>> k;
    endfunction

    function automatic logic signed [VecW-1:0] sat36(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (VecW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) return hi[VecW-1:0];
        if (x < lo) return lo[VecW-1:0];
        return x[VecW-1:0];
    endfunction

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (CoordW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) return hi[CoordW-1:0];
        if (x < lo) return lo[CoordW-1:0];
        return x[CoordW-1:0];
    endfunction
endpackage

FILE: hdl/rpft_rotate.sv
// Four-stage pipelined quaternion rotation of one vector, with stall support.
`timescale 1ns / 1ps
module rpft_rotate (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  rpft_pkg::quat_t                         q,
    input  logic signed [rpft_pkg::VecW-1:0]        vx,
    input  logic signed [rpft_pkg::VecW-1:0]        vy,
    input  logic signed [rpft_pkg::VecW-1:0]        vz,
    input  rpft_pkg::attr_t                         in_attr,
    output logic                                    out_valid,
    output logic signed [63:0]                      rx,
    output logic signed [63:0]                      ry,
    output logic signed [63:0]                      rz,
    output rpft_pkg::attr_t                         out_attr
);
    import rpft_pkg::*;

    // Stage 1: the six products of q x v.
    logic signed [63:0] p1_reg [6];
    logic signed [VecW-1:0] v1_reg [3];
    logic valid1_reg;
    attr_t attr1_reg;
    // Stage 2: rounded cross product c.
    logic signed [63:0] c2_reg [3];
    logic signed [VecW-1:0] v2_reg [3];
    logic valid2_reg;
    attr_t attr2_reg;
    // Stage 3: products of q x c and w*c.
    logic signed [63:0] d3_reg [6];
    logic signed [63:0] wc3_reg [3];
    logic signed [VecW-1:0] v3_reg [3];
    logic valid3_reg;
    attr_t attr3_reg;
    // Stage 4: final sum rounded to 1/1024 m.
    logic signed [63:0] r4_reg [3];
    logic valid4_reg;
    attr_t attr4_reg;

    logic signed [63:0] qx, qy, qz, qw;
    assign qx = 64'(q.x);
    assign qy = 64'(q.y);
    assign qz = 64'(q.z);
    assign qw = 64'(q.w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg[0] <= qy * 64'(vz);
            p1_reg[1] <= qz * 64'(vy);
            p1_reg[2] <= qz * 64'(vx);
            p1_reg[3] <= qx * 64'(vz);
            p1_reg[4] <= qx * 64'(vy);
            p1_reg[5] <= qy * 64'(vx);
            v1_reg[0] <= vx;
            v1_reg[1] <= vy;
            v1_reg[2] <= vz;
            attr1_reg <= in_attr;

            c2_reg[0] <= shr_round(p1_reg[0] - p1_reg[1], 8);
            c2_reg[1] <= shr_round(p1_reg[2] - p1_reg[3], 8);
            c2_reg[2] <= shr_round(p1_reg[4] - p1_reg[5], 8);
            v2_reg <= v1_reg;
            attr2_reg <= attr1_reg;

            d3_reg[0] <= qy * c2_reg[2];
            d3_reg[1] <= qz * c2_reg[1];
            d3_reg[2] <= qz * c2_reg[0];
            d3_reg[3] <= qx * c2_reg[2];
            d3_reg[4] <= qx * c2_reg[1];
            d3_reg[5] <= qy * c2_reg[0];
            wc3_reg[0] <= qw * c2_reg[0];
            wc3_reg[1] <= qw * c2_reg[1];
            wc3_reg[2] <= qw * c2_reg[2];
            v3_reg <= v2_reg;
            attr3_reg <= attr2_reg;

            for (int i = 0; i < 3; i++) begin
                r4_reg[i] <= shr_round((64'(v3_reg[i]) <<< 20) + 2 * wc3_reg[i]
                    + 2 * (d3_reg[2*i] - d3_reg[2*i+1]), 20);
            end
            attr4_reg <= attr3_reg;
        end
    end

    assign out_valid = valid4_reg;
    assign rx = r4_reg[0];
    assign ry = r4_reg[1];
    assign rz = r4_reg[2];
    assign out_attr = attr4_reg;
endmodule

FILE: hdl/radar_point_frame_transform.sv
// Top level of the radar point frame transform: registers, two rotations and output stage.
`timescale 1ns / 1ps
// Each beat on the slave stream is one radar point in the frame of the pose at which
// it was received. The block rotates it by the received quaternion, adds the received
// position, subtracts the current position, and rotates by the conjugate of the current
// quaternion, giving the point in the current vehicle frame; coordinates saturate to
// 32 bits and the three attributes pass through. The pipeline takes one beat per clock
// while not held, with four stages per rotation, one for the position offset and one
// output register. The whole pipeline advances together and holds while the output
// register is full and not taken. The user must write the pose registers through the
// plain write port only while no beat is in flight; the block does not enforce this.
module radar_point_frame_transform (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [rpft_pkg::IdxW-1:0]            cfg_index,
    input  logic [rpft_pkg::RegW-1:0]            cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // point_x, point_y, point_z, radar_velocity, ground_velocity, snr_in
    input  logic [rpft_pkg::TdataInW-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_x, out_y, out_z, out_radar_velocity, out_ground_velocity, snr_out
    output logic [rpft_pkg::TdataOutW-1:0]       m_tdata
);
    import rpft_pkg::*;
    `include "radar_point_frame_transform_macros.svh"

    logic [RegW-1:0] rx_rot_reg, cur_rot_reg;
    logic signed [CoordW-1:0] rx_e_reg, rx_n_reg, rx_u_reg;
    logic signed [CoordW-1:0] cur_e_reg, cur_n_reg, cur_u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_rot_reg  <= RegW'(16384);
            cur_rot_reg <= RegW'(16384);
            rx_e_reg <= '0; rx_n_reg <= '0; rx_u_reg <= '0;
            cur_e_reg <= '0; cur_n_reg <= '0; cur_u_reg <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_RX_ROT:    rx_rot_reg <= cfg_data;
                REG_RX_EAST:   rx_e_reg <= cfg_data[CoordW-1:0];
                REG_RX_NORTH:  rx_n_reg <= cfg_data[CoordW-1:0];
                REG_RX_UP:     rx_u_reg <= cfg_data[CoordW-1:0];
                REG_CUR_ROT:   cur_rot_reg <= cfg_data;
                REG_CUR_EAST:  cur_e_reg <= cfg_data[CoordW-1:0];
                REG_CUR_NORTH: cur_n_reg <= cfg_data[CoordW-1:0];
                REG_CUR_UP:    cur_u_reg <= cfg_data[CoordW-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is empty or being taken.
    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    attr_t in_attr;
    assign in_attr.radar_velocity  = s_tdata[3*CoordW +: AttrW];
    assign in_attr.ground_velocity = s_tdata[3*CoordW+AttrW +: AttrW];
    assign in_attr.snr             = s_tdata[3*CoordW+2*AttrW +: AttrW];

    logic a_valid;
    logic signed [63:0] ax, ay, az;
    attr_t a_attr;

    rpft_rotate u_rot_rx (
        .aclk, .aresetn, .en,
        .in_valid(s_tvalid),
        .q(unpack_quat(rx_rot_reg, 1'b0)),
        .vx(VecW'($signed(s_tdata[0 +: CoordW]))),
        .vy(VecW'($signed(s_tdata[CoordW +: CoordW]))),
        .vz(VecW'($signed(s_tdata[2*CoordW +: CoordW]))),
        .in_attr,
        .out_valid(a_valid), .rx(ax), .ry(ay), .rz(az), .out_attr(a_attr)
    );

    // Position offset stage, saturated to the 36-bit intermediate range.
    logic e_valid_reg;
    logic signed [VecW-1:0] ex_reg, ey_reg, ez_reg;
    attr_t e_attr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= a_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg <= sat36(ax + 64'(rx_e_reg) - 64'(cur_e_reg));
            ey_reg <= sat36(ay + 64'(rx_n_reg) - 64'(cur_n_reg));
            ez_reg <= sat36(az + 64'(rx_u_reg) - 64'(cur_u_reg));
            e_attr_reg <= a_attr;
        end
    end

    logic b_valid;
    logic signed [63:0] bx, by, bz;
    attr_t b_attr;

    rpft_rotate u_rot_cur (
        .aclk, .aresetn, .en,
        .in_valid(e_valid_reg),
        .q(unpack_quat(cur_rot_reg, 1'b1)),
        .vx(ex_reg), .vy(ey_reg), .vz(ez_reg),
        .in_attr(e_attr_reg),
        .out_valid(b_valid), .rx(bx), .ry(by), .rz(bz), .out_attr(b_attr)
    );

    // Output register: holds a finished beat until the master side takes it.
    logic [TdataOutW-1:0] out_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= b_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {b_attr.snr, b_attr.ground_velocity, b_attr.radar_velocity,
                             sat32(bz), sat32(by), sat32(bx)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `RPFT_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    `RPFT_ASSERT_IMP(a_ready_rule, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input accepted while output stalled")
    `RPFT_ASSERT_NEXT(a_offset_hold, aclk, aresetn, !en, $stable(e_valid_reg), "offset stage moved during a stall")
endmodule
